/* rtl/bank_switch_mapper_scanline_irq_macros.svh */
// ----------------------------------------------------------------------------
// Bank mapper assertion macros
// Shared concurrent assertion forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef BANK_SWITCH_MAPPER_SCANLINE_IRQ_MACROS_SVH
`define BANK_SWITCH_MAPPER_SCANLINE_IRQ_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define BSM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bank mapper check failed");

// Next-cycle implication, ignored while reset is asserted.
`define BSM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bank mapper check failed");

// Condition that must hold in the cycle after a reset cycle.
`define BSM_ASSERT_RST(lbl, cons) \
  lbl: assert property (@(posedge clk) !rst_n |=> (cons)) \
    else $error("bank mapper reset check failed");

`endif

/* rtl/bsm_pkg.sv */
// ----------------------------------------------------------------------------
// Bank mapper package
// Operation codes, command codes, register indices, queue entry and config shared by the mapper modules.
// ----------------------------------------------------------------------------
package bsm_pkg;

  typedef enum logic [2:0] {
    OP_REG_WR  = 3'd0,
    OP_SAVE_WR = 3'd1,
    OP_TICK    = 3'd2,
    OP_PRG     = 3'd3,
    OP_CHR     = 3'd4
  } op_t;

  typedef enum logic [3:0] {
    CMD_NOP     = 4'd0,
    CMD_MODE    = 4'd1,
    CMD_BANK    = 4'd2,
    CMD_MIRROR  = 4'd3,
    CMD_CNT     = 4'd4,
    CMD_LATCH   = 4'd5,
    CMD_IRQ_OFF = 4'd6,
    CMD_IRQ_ON  = 4'd7,
    CMD_RESTORE = 4'd8,
    CMD_TICK    = 4'd9,
    CMD_PRG     = 4'd10,
    CMD_CHR     = 4'd11
  } cmd_t;

  typedef enum logic [1:0] {
    REG_PRG_UNITS   = 2'd0,
    REG_CHR_UNITS   = 2'd1,
    REG_FOUR_SCREEN = 2'd2
  } reg_idx_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [2:0] slot;
    logic [7:0] data;
  } entry_t;

  typedef struct packed {
    logic [7:0] prg_units;
    logic [5:0] chr_units;
    logic       four_screen;
  } cfg_t;

  localparam logic [15:0] RESTORE_ADDR = 16'h6000;
  localparam logic [8:0]  LAST_VISIBLE = 9'd239;
  localparam logic [7:0]  CHR_EVEN_MASK = 8'hFE;

endpackage

/* rtl/bsm_front.sv */
// ----------------------------------------------------------------------------
// Bank mapper front end
// Decodes each incoming item into a command for the queue.
// ----------------------------------------------------------------------------
module bsm_front (
  input  logic [2:0]      in_operation,
  input  logic [15:0]     in_address,
  input  logic [7:0]      in_data,
  input  logic [8:0]      in_scanline,
  input  logic            in_rendering_enabled,
  output bsm_pkg::entry_t entry
);

  logic [3:0] dec;

  // Register decode is address AND 0xE001: bits 15..13 and bit 0.
  assign dec = {in_address[15:13], in_address[0]};

  always_comb begin
    entry.cmd  = bsm_pkg::CMD_NOP;
    entry.slot = 3'd0;
    entry.data = in_data;
    case (in_operation)
      bsm_pkg::OP_REG_WR: begin
        case (dec)
          4'b1000: entry.cmd = bsm_pkg::CMD_MODE;
          4'b1001: entry.cmd = bsm_pkg::CMD_BANK;
          4'b1010: entry.cmd = bsm_pkg::CMD_MIRROR;
          4'b1100: entry.cmd = bsm_pkg::CMD_CNT;
          4'b1101: entry.cmd = bsm_pkg::CMD_LATCH;
          4'b1110: entry.cmd = bsm_pkg::CMD_IRQ_OFF;
          4'b1111: entry.cmd = bsm_pkg::CMD_IRQ_ON;
          default: entry.cmd = bsm_pkg::CMD_NOP;
        endcase
      end
      bsm_pkg::OP_SAVE_WR: begin
        if (in_address == bsm_pkg::RESTORE_ADDR && in_data == 8'd0) begin
          entry.cmd = bsm_pkg::CMD_RESTORE;
        end
      end
      bsm_pkg::OP_TICK: begin
        if (in_scanline <= bsm_pkg::LAST_VISIBLE && in_rendering_enabled) begin
          entry.cmd = bsm_pkg::CMD_TICK;
        end
      end
      bsm_pkg::OP_PRG: begin
        entry.cmd  = bsm_pkg::CMD_PRG;
        entry.slot = {1'b0, in_address[14:13]};
      end
      bsm_pkg::OP_CHR: begin
        entry.cmd  = bsm_pkg::CMD_CHR;
        entry.slot = in_address[12:10];
      end
      default: entry.cmd = bsm_pkg::CMD_NOP;
    endcase
  end

endmodule

/* rtl/bsm_queue.sv */
// ----------------------------------------------------------------------------
// Bank mapper command queue
// Two-entry queue between the decoder and the execution unit.
// ----------------------------------------------------------------------------
module bsm_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  bsm_pkg::entry_t push_entry,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output bsm_pkg::entry_t head
);

  bsm_pkg::entry_t mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign head      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

/* rtl/bsm_back.sv */
// ----------------------------------------------------------------------------
// Bank mapper execution unit
// Holds the mapper state, runs commands and reduces pages modulo ROM size.
// ----------------------------------------------------------------------------
module bsm_back (
  input  logic            clk,
  input  logic            rst_n,
  input  bsm_pkg::cfg_t   cfg,
  input  logic            q_not_empty,
  input  bsm_pkg::entry_t q_head,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [7:0]      out_prg_page,
  output logic [7:0]      out_chr_page,
  output logic            out_chr_mapped,
  output logic            out_irq_request,
  output logic            out_mirroring_horizontal,
  output logic            out_mirroring_update
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DIV  = 2'b10
  } state_t;

  state_t     state_r, state_nxt;
  logic [7:0] mode_r, mode_nxt;
  logic [7:0] prg_bank_r [2];
  logic [7:0] prg_bank_nxt [2];
  logic [7:0] chr_bank_r [6];
  logic [7:0] chr_bank_nxt [6];
  logic [7:0] irq_cnt_r, irq_cnt_nxt;
  logic [7:0] irq_rld_r, irq_rld_nxt;
  logic       irq_en_r, irq_en_nxt;
  logic       mir_r, mir_nxt;

  logic [8:0] rem_r, rem_nxt;
  logic [7:0] dvd_r, dvd_nxt;
  logic [8:0] dvs_r, dvs_nxt;
  logic [2:0] step_r, step_nxt;
  logic       div_chr_r, div_chr_nxt;

  logic       ov_r, ov_nxt;
  logic [7:0] o_prg_r, o_prg_nxt;
  logic [7:0] o_chr_r, o_chr_nxt;
  logic       o_map_r, o_map_nxt;
  logic       o_irq_r, o_irq_nxt;
  logic       o_upd_r, o_upd_nxt;

  logic       slot_free;
  logic [7:0] prg_units;
  logic [5:0] chr_units;
  logic [8:0] prg_count;
  logic [8:0] chr_count;
  logic [2:0] cslot;
  logic [2:0] sel;
  logic [7:0] chr_pick;
  logic [7:0] chr_sum;
  logic [8:0] trial;

  assign slot_free = !ov_r || !out_stall;
  assign q_pop     = (state_r == ST_IDLE) && q_not_empty && slot_free;

  assign prg_units = (cfg.prg_units > 8'd128) ? 8'd128 : cfg.prg_units;
  assign chr_units = (cfg.chr_units > 6'd32) ? 6'd32 : cfg.chr_units;
  assign prg_count = {prg_units, 1'b0};
  assign chr_count = {chr_units, 3'b000};
  assign sel       = mode_r[2:0];

  // The pattern swap bit exchanges the two halves of the pattern space.
  assign cslot = q_head.slot ^ {mode_r[7], 2'b00};
  always_comb begin
    if (!cslot[2]) begin
      chr_pick = chr_bank_r[{2'b00, cslot[1]}];
      chr_sum  = chr_pick + {7'd0, cslot[0]};
    end else begin
      chr_pick = chr_bank_r[{1'b0, cslot[1:0]} + 3'd2];
      chr_sum  = chr_pick;
    end
  end

  assign trial = {rem_r[7:0], dvd_r[7]};

  always_comb begin
    state_nxt   = state_r;
    mode_nxt    = mode_r;
    prg_bank_nxt = prg_bank_r;
    chr_bank_nxt = chr_bank_r;
    irq_cnt_nxt = irq_cnt_r;
    irq_rld_nxt = irq_rld_r;
    irq_en_nxt  = irq_en_r;
    mir_nxt     = mir_r;
    rem_nxt     = rem_r;
    dvd_nxt     = dvd_r;
    dvs_nxt     = dvs_r;
    step_nxt    = step_r;
    div_chr_nxt = div_chr_r;
    ov_nxt      = ov_r && out_stall;
    o_prg_nxt   = o_prg_r;
    o_chr_nxt   = o_chr_r;
    o_map_nxt   = o_map_r;
    o_irq_nxt   = o_irq_r;
    o_upd_nxt   = o_upd_r;

    case (state_r)
      ST_IDLE: begin
        if (q_pop) begin
          ov_nxt    = 1'b1;
          o_prg_nxt = 8'd0;
          o_chr_nxt = 8'd0;
          o_map_nxt = 1'b0;
          o_irq_nxt = 1'b0;
          o_upd_nxt = 1'b0;
          rem_nxt   = 9'd0;
          step_nxt  = 3'd0;
          case (q_head.cmd)
            bsm_pkg::CMD_MODE: mode_nxt = q_head.data;
            bsm_pkg::CMD_BANK: begin
              if (sel >= 3'd6) begin
                prg_bank_nxt[sel[0]] = q_head.data;
              end else if (cfg.chr_units != 6'd0) begin
                chr_bank_nxt[sel] = (sel < 3'd2) ? (q_head.data & bsm_pkg::CHR_EVEN_MASK)
                                                 : q_head.data;
              end
            end
            bsm_pkg::CMD_MIRROR: begin
              if (!cfg.four_screen) begin
                mir_nxt   = q_head.data[0];
                o_upd_nxt = q_head.data[0] != mir_r;
              end
            end
            bsm_pkg::CMD_CNT:     irq_cnt_nxt = q_head.data;
            bsm_pkg::CMD_LATCH:   irq_rld_nxt = q_head.data;
            bsm_pkg::CMD_IRQ_OFF: irq_en_nxt = 1'b0;
            bsm_pkg::CMD_IRQ_ON:  irq_en_nxt = 1'b1;
            bsm_pkg::CMD_RESTORE: begin
              mode_nxt        = 8'd0;
              prg_bank_nxt[0] = 8'd0;
              prg_bank_nxt[1] = 8'd1;
              chr_bank_nxt[0] = 8'd0;
              chr_bank_nxt[1] = 8'd2;
              chr_bank_nxt[2] = 8'd4;
              chr_bank_nxt[3] = 8'd5;
              chr_bank_nxt[4] = 8'd6;
              chr_bank_nxt[5] = 8'd7;
              irq_en_nxt      = 1'b0;
              irq_cnt_nxt     = 8'd0;
              irq_rld_nxt     = 8'd0;
            end
            bsm_pkg::CMD_TICK: begin
              if (irq_en_r) begin
                if (irq_cnt_r == 8'd0) begin
                  irq_cnt_nxt = irq_rld_r;
                  o_irq_nxt   = 1'b1;
                end else begin
                  irq_cnt_nxt = irq_cnt_r - 8'd1;
                end
              end
            end
            bsm_pkg::CMD_PRG: begin
              // The fixed slots need no reduction; banked slots go to the divider.
              if (prg_count == 9'd0) begin
                o_prg_nxt = 8'd0;
              end else if (q_head.slot[1:0] == 2'd3) begin
                o_prg_nxt = 8'(prg_count - 9'd1);
              end else if (q_head.slot[1:0] == 2'd1) begin
                ov_nxt      = 1'b0;
                dvd_nxt     = prg_bank_r[1];
                dvs_nxt     = prg_count;
                div_chr_nxt = 1'b0;
                state_nxt   = ST_DIV;
              end else if ((q_head.slot[1:0] == 2'd0) != mode_r[6]) begin
                ov_nxt      = 1'b0;
                dvd_nxt     = prg_bank_r[0];
                dvs_nxt     = prg_count;
                div_chr_nxt = 1'b0;
                state_nxt   = ST_DIV;
              end else begin
                o_prg_nxt = 8'(prg_count - 9'd2);
              end
            end
            bsm_pkg::CMD_CHR: begin
              if (cfg.chr_units != 6'd0) begin
                ov_nxt      = 1'b0;
                dvd_nxt     = chr_sum;
                dvs_nxt     = chr_count;
                div_chr_nxt = 1'b1;
                state_nxt   = ST_DIV;
              end
            end
            default: ;
          endcase
        end
      end
      ST_DIV: begin
        // Restoring remainder, one dividend bit per cycle.
        rem_nxt  = (trial >= dvs_r) ? (trial - dvs_r) : trial;
        dvd_nxt  = {dvd_r[6:0], 1'b0};
        step_nxt = step_r + 3'd1;
        if (step_r == 3'd7) begin
          state_nxt = ST_IDLE;
          ov_nxt    = 1'b1;
          if (div_chr_r) begin
            o_chr_nxt = rem_nxt[7:0];
            o_map_nxt = 1'b1;
          end else begin
            o_prg_nxt = rem_nxt[7:0];
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      mode_r        <= 8'd0;
      prg_bank_r[0] <= 8'd0;
      prg_bank_r[1] <= 8'd1;
      chr_bank_r[0] <= 8'd0;
      chr_bank_r[1] <= 8'd2;
      chr_bank_r[2] <= 8'd4;
      chr_bank_r[3] <= 8'd5;
      chr_bank_r[4] <= 8'd6;
      chr_bank_r[5] <= 8'd7;
      irq_cnt_r     <= 8'd0;
      irq_rld_r     <= 8'd0;
      irq_en_r      <= 1'b0;
      mir_r         <= 1'b0;
      ov_r          <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      mode_r     <= mode_nxt;
      prg_bank_r <= prg_bank_nxt;
      chr_bank_r <= chr_bank_nxt;
      irq_cnt_r  <= irq_cnt_nxt;
      irq_rld_r  <= irq_rld_nxt;
      irq_en_r   <= irq_en_nxt;
      mir_r      <= mir_nxt;
      ov_r       <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r     <= rem_nxt;
    dvd_r     <= dvd_nxt;
    dvs_r     <= dvs_nxt;
    step_r    <= step_nxt;
    div_chr_r <= div_chr_nxt;
    o_prg_r   <= o_prg_nxt;
    o_chr_r   <= o_chr_nxt;
    o_map_r   <= o_map_nxt;
    o_irq_r   <= o_irq_nxt;
    o_upd_r   <= o_upd_nxt;
  end

  assign out_valid                = ov_r;
  assign out_prg_page             = o_prg_r;
  assign out_chr_page             = o_chr_r;
  assign out_chr_mapped           = o_map_r;
  assign out_irq_request          = o_irq_r;
  assign out_mirroring_horizontal = mir_r;
  assign out_mirroring_update     = o_upd_r;

endmodule

/* rtl/bank_switch_mapper_scanline_irq.sv */
// ----------------------------------------------------------------------------
// Bank switch mapper with scanline interrupt
// Decoder, two-entry command queue and execution unit with a serial divider.
// ----------------------------------------------------------------------------
//  channel | kind          | handshake
//  in_*    | item input    | in_valid / in_stall
//  out_*   | result output | out_valid / out_stall
//  psel... | register port | psel, penable, pwrite, pready
//
// Writes, ticks and fixed-slot translations pass through the queue and the
// output register; banked translations also pass through the eight-step
// remainder unit. The execution unit runs one item at a time; the queue keeps
// taking up to two items while it works. Reset is synchronous and restores the
// boot banks. A stalled result holds the execution unit but not the queue.
module bank_switch_mapper_scanline_irq (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_operation,
  input  logic [15:0] in_address,
  input  logic [7:0]  in_data,
  input  logic [8:0]  in_scanline,
  input  logic        in_rendering_enabled,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_prg_page,
  output logic [7:0]  out_chr_page,
  output logic        out_chr_mapped,
  output logic        out_irq_request,
  output logic        out_mirroring_horizontal,
  output logic        out_mirroring_update,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  bsm_pkg::entry_t entry;
  bsm_pkg::entry_t head;
  bsm_pkg::cfg_t   cfg_r;
  logic            q_full;
  logic            q_not_empty;
  logic            q_pop;
  logic            push;
  logic            cfg_wr;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prg_units   <= 8'd2;
      cfg_r.chr_units   <= 6'd0;
      cfg_r.four_screen <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        bsm_pkg::REG_PRG_UNITS:   cfg_r.prg_units   <= pwdata[7:0];
        bsm_pkg::REG_CHR_UNITS:   cfg_r.chr_units   <= pwdata[5:0];
        bsm_pkg::REG_FOUR_SCREEN: cfg_r.four_screen <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      bsm_pkg::REG_PRG_UNITS:   prdata = {24'd0, cfg_r.prg_units};
      bsm_pkg::REG_CHR_UNITS:   prdata = {26'd0, cfg_r.chr_units};
      bsm_pkg::REG_FOUR_SCREEN: prdata = {31'd0, cfg_r.four_screen};
      default:                  prdata = 32'd0;
    endcase
  end

  bsm_front u_front (
    .in_operation         (in_operation),
    .in_address           (in_address),
    .in_data              (in_data),
    .in_scanline          (in_scanline),
    .in_rendering_enabled (in_rendering_enabled),
    .entry                (entry)
  );

  bsm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (entry),
    .full       (q_full),
    .pop        (q_pop),
    .not_empty  (q_not_empty),
    .head       (head)
  );

  bsm_back u_back (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .cfg                      (cfg_r),
    .q_not_empty              (q_not_empty),
    .q_head                   (head),
    .q_pop                    (q_pop),
    .out_valid                (out_valid),
    .out_stall                (out_stall),
    .out_prg_page             (out_prg_page),
    .out_chr_page             (out_chr_page),
    .out_chr_mapped           (out_chr_mapped),
    .out_irq_request          (out_irq_request),
    .out_mirroring_horizontal (out_mirroring_horizontal),
    .out_mirroring_update     (out_mirroring_update)
  );

endmodule

/* rtl/bsm_checker.sv */
// ----------------------------------------------------------------------------
// Bank mapper port checker
// Port-level properties of the mapper, attached by bind.
// ----------------------------------------------------------------------------
`include "bank_switch_mapper_scanline_irq_macros.svh"

module bsm_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_prg_page,
  input logic [7:0] out_chr_page,
  input logic       out_chr_mapped,
  input logic       out_irq_request,
  input logic       out_mirroring_update
);

  `BSM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_prg_page))
  `BSM_ASSERT_IMP(a_one_kind, out_valid && out_chr_mapped, out_prg_page == 8'd0)
  `BSM_ASSERT_IMP(a_chr_zero, out_valid && !out_chr_mapped, out_chr_page == 8'd0)
  `BSM_ASSERT_IMP(a_irq_vs_upd, out_valid && out_irq_request, !out_mirroring_update)
  `BSM_ASSERT_RST(a_reset_empty, !out_valid)

endmodule

bind bank_switch_mapper_scanline_irq bsm_checker u_bsm_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .out_valid            (out_valid),
  .out_stall            (out_stall),
  .out_prg_page         (out_prg_page),
  .out_chr_page         (out_chr_page),
  .out_chr_mapped       (out_chr_mapped),
  .out_irq_request      (out_irq_request),
  .out_mirroring_update (out_mirroring_update)
);

/* verif/bank_switch_mapper_scanline_irq_test.sv */
// ----------------------------------------------------------------------------
// Bank mapper scanline IRQ testbench
// Drives register writes, restore writes, scanline ticks and translations
// through the input channel with random gaps and stalls. A behavioral model
// of the mapper state predicts every result, and the monitor compares each
// received transfer with the oldest prediction field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bank_switch_mapper_scanline_irq_test;

  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] addr;
    logic [7:0]  data;
    logic [8:0]  line;
    logic        render;
  } item_t;

  typedef struct packed {
    logic [7:0] prg;
    logic [7:0] chr;
    logic       mapped;
    logic       irq;
    logic       mirr;
    logic       upd;
  } result_t;

  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] in_operation = '0;
  logic [15:0] in_address = '0;
  logic [7:0] in_data = '0;
  logic [8:0] in_scanline = '0;
  logic in_rendering_enabled = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] out_prg_page;
  logic [7:0] out_chr_page;
  logic out_chr_mapped;
  logic out_irq_request;
  logic out_mirroring_horizontal;
  logic out_mirroring_update;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  bank_switch_mapper_scanline_irq dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Mapper model state.
  logic [7:0] m_prg_units, m_mode, m_counter, m_latch;
  logic [5:0] m_chr_units;
  logic m_four, m_irq_en, m_mirr;
  logic [7:0] m_prg_bank [2];
  logic [7:0] m_chr_bank [6];

  item_t pending_items[$];
  result_t expected_results[$];
  int errors = 0;
  int idle_cycles = 0;
  bit hold_receiver = 1'b0;
  int sender_gap = 0;

  function automatic void restore_boot_banks();
    m_mode = 0;
    m_prg_bank[0] = 0; m_prg_bank[1] = 1;
    m_chr_bank[0] = 0; m_chr_bank[1] = 2; m_chr_bank[2] = 4;
    m_chr_bank[3] = 5; m_chr_bank[4] = 6; m_chr_bank[5] = 7;
    m_irq_en = 0; m_counter = 0; m_latch = 0;
  endfunction

  function automatic logic [7:0] prg_page_of(logic [15:0] a);
    int units, count, slot, bank;
    bit swap;
    units = (m_prg_units > 128) ? 128 : m_prg_units;
    count = units * 2;
    slot = a[14:13];
    swap = m_mode[6];
    if (count == 0) return 8'd0;
    if (slot == 3) return 8'(count - 1);
    if (slot == 1) return 8'(m_prg_bank[1] % count);
    if ((slot == 0) != swap) return 8'(m_prg_bank[0] % count);
    bank = count - 2;
    return 8'(bank);
  endfunction

  function automatic logic [7:0] chr_page_of(logic [15:0] a);
    int units, count, slot, bank;
    units = (m_chr_units > 32) ? 32 : m_chr_units;
    count = units * 8;
    slot = a[12:10];
    if (m_mode[7]) slot = slot ^ 4;
    if (slot < 4) bank = m_chr_bank[slot >> 1] + (slot & 1);
    else bank = m_chr_bank[slot - 2];
    return 8'(bank % count);
  endfunction

  function automatic result_t predict_mapper(item_t it);
    result_t r;
    int sel;
    r = '0;
    case (it.op)
      bsm_pkg::OP_REG_WR: begin
        case (it.addr & 16'hE001)
          16'h8000: m_mode = it.data;
          16'h8001: begin
            sel = m_mode[2:0];
            if (sel >= 6) m_prg_bank[sel - 6] = it.data;
            else if (m_chr_units != 0)
              m_chr_bank[sel] = (sel < 2) ? (it.data & bsm_pkg::CHR_EVEN_MASK) : it.data;
          end
          16'hA000: if (!m_four) begin
            if (it.data[0] != m_mirr) r.upd = 1'b1;
            m_mirr = it.data[0];
          end
          16'hC000: m_counter = it.data;
          16'hC001: m_latch = it.data;
          16'hE000: m_irq_en = 1'b0;
          16'hE001: m_irq_en = 1'b1;
          default: ;
        endcase
      end
      bsm_pkg::OP_SAVE_WR:
        if (it.addr == bsm_pkg::RESTORE_ADDR && it.data == 8'd0) restore_boot_banks();
      bsm_pkg::OP_TICK: if (m_irq_en && it.line <= bsm_pkg::LAST_VISIBLE && it.render) begin
        if (m_counter == 8'd0) begin
          m_counter = m_latch;
          r.irq = 1'b1;
        end else begin
          m_counter = m_counter - 8'd1;
        end
      end
      bsm_pkg::OP_PRG: r.prg = prg_page_of(it.addr);
      bsm_pkg::OP_CHR: if (m_chr_units != 0) begin
        r.mapped = 1'b1;
        r.chr = chr_page_of(it.addr);
      end
      default: ;
    endcase
    r.mirr = m_mirr;
    return r;
  endfunction

  function automatic int random_gap();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  // Driver: offers queued items, holds the payload while stalled.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(predict_mapper(item_t'({in_operation, in_address,
                                   in_data, in_scanline, in_rendering_enabled})));
        sender_gap <= random_gap();
      end
      if (!(in_valid && in_stall)) begin
        if ((in_valid && !in_stall) ? (random_gap() == 0 && pending_items.size() > 0)
            : (sender_gap == 0 && pending_items.size() > 0)) begin
          item_t it;
          it = pending_items.pop_front();
          in_valid <= 1'b1;
          in_operation <= it.op;
          in_address <= it.addr;
          in_data <= it.data;
          in_scanline <= it.line;
          in_rendering_enabled <= it.render;
        end else begin
          in_valid <= 1'b0;
          if (sender_gap > 0 && !(in_valid && !in_stall)) sender_gap <= sender_gap - 1;
        end
      end
    end
  end

  // Monitor and receiver stalls.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        result_t got, exp;
        got = {out_prg_page, out_chr_page, out_chr_mapped, out_irq_request,
               out_mirroring_horizontal, out_mirroring_update};
        if (expected_results.size() == 0) begin
          $error("result transfer with no prediction waiting");
          errors++;
        end else begin
          exp = expected_results.pop_front();
          if (got.prg != exp.prg) begin
            $error("prg_page expected %0d got %0d", exp.prg, got.prg); errors++;
          end
          if (got.chr != exp.chr) begin
            $error("chr_page expected %0d got %0d", exp.chr, got.chr); errors++;
          end
          if (got.mapped != exp.mapped) begin
            $error("chr_mapped expected %0d got %0d", exp.mapped, got.mapped); errors++;
          end
          if (got.irq != exp.irq) begin
            $error("irq_request expected %0d got %0d", exp.irq, got.irq); errors++;
          end
          if (got.mirr != exp.mirr) begin
            $error("mirroring_horizontal expected %0d got %0d", exp.mirr, got.mirr);
            errors++;
          end
          if (got.upd != exp.upd) begin
            $error("mirroring_update expected %0d got %0d", exp.upd, got.upd); errors++;
          end
        end
      end
      out_stall <= hold_receiver ? 1'b1 : ($urandom_range(0, 3) == 0);
    end
  end

  // Watchdog: counts cycles with no transfer on either channel.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("bank_switch_mapper_scanline_irq_test: errors");
      $finish;
    end
  end

  task automatic cfg_write(bsm_pkg::reg_idx_t idx, logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 4'(idx) << 2; pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      bsm_pkg::REG_PRG_UNITS: m_prg_units = value[7:0];
      bsm_pkg::REG_CHR_UNITS: m_chr_units = value[5:0];
      bsm_pkg::REG_FOUR_SCREEN: m_four = value[0];
      default: ;
    endcase
  endtask

  task automatic drain_results();
    while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic item_t mapper_write(logic [15:0] a, logic [7:0] d);
    return item_t'({bsm_pkg::OP_REG_WR, a, d, 9'($urandom), 1'($urandom)});
  endfunction

  function automatic item_t random_item();
    item_t it;
    int pick;
    it = item_t'(37'({$urandom, $urandom}));
    it.line = 9'($urandom_range(0, 261));
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      it.op = bsm_pkg::OP_REG_WR;
      it.addr = {3'($urandom_range(3, 7)), 12'($urandom), 1'($urandom)};
      if ($urandom_range(0, 9) == 0) it.addr = 16'($urandom);
    end else if (pick < 34) begin
      it.op = bsm_pkg::OP_SAVE_WR;
      if ($urandom_range(0, 1)) begin it.addr = bsm_pkg::RESTORE_ADDR; it.data = 8'd0; end
    end else if (pick < 60) begin
      it.op = bsm_pkg::OP_TICK;
      it.line = ($urandom_range(0, 4) == 0) ? 9'($urandom_range(240, 261))
                                            : 9'($urandom_range(0, 239));
      it.render = ($urandom_range(0, 5) != 0);
    end else if (pick < 78) begin
      it.op = bsm_pkg::OP_PRG;
    end else if (pick < 97) begin
      it.op = bsm_pkg::OP_CHR;
    end else begin
      it.op = 3'($urandom_range(5, 7));
    end
    return it;
  endfunction

  initial begin
    int prg_set[5] = '{2, 1, 128, 0, 255};
    int chr_set[5] = '{0, 32, 3, 63, 1};
    m_prg_units = 2; m_chr_units = 0; m_four = 0; m_mirr = 0;
    restore_boot_banks();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part under the reset configuration, without pattern ROM.
    pending_items.push_back(item_t'({bsm_pkg::OP_PRG, 16'h0000, 8'h00, 9'd0, 1'b0}));
    pending_items.push_back(item_t'({bsm_pkg::OP_PRG, 16'hFFFF, 8'hFF, 9'h1FF, 1'b1}));
    pending_items.push_back(item_t'({bsm_pkg::OP_CHR, 16'h1C00, 8'h00, 9'd0, 1'b0}));
    pending_items.push_back(mapper_write(16'h8000, 8'h00));
    pending_items.push_back(mapper_write(16'h8001, 8'hFF));
    pending_items.push_back(mapper_write(16'h7FFF, 8'h55));
    pending_items.push_back(mapper_write(16'hA000, 8'h01));
    pending_items.push_back(mapper_write(16'hA001, 8'hFF));
    pending_items.push_back(mapper_write(16'hC000, 8'h01));
    pending_items.push_back(mapper_write(16'hC001, 8'h02));
    pending_items.push_back(mapper_write(16'hE001, 8'h00));
    for (int k = 0; k < 4; k++)
      pending_items.push_back(item_t'({bsm_pkg::OP_TICK, 16'h0, 8'h0, 9'd239, 1'b1}));
    pending_items.push_back(item_t'({bsm_pkg::OP_TICK, 16'h0, 8'h0, 9'd240, 1'b1}));
    pending_items.push_back(item_t'({bsm_pkg::OP_TICK, 16'h0, 8'h0, 9'd10, 1'b0}));
    pending_items.push_back(mapper_write(16'hE000, 8'h00));
    pending_items.push_back(item_t'({3'd7, 16'hFFFF, 8'hFF, 9'h1FF, 1'b1}));
    pending_items.push_back(item_t'({bsm_pkg::OP_SAVE_WR, 16'h6000, 8'h01, 9'd0, 1'b0}));
    pending_items.push_back(item_t'({bsm_pkg::OP_SAVE_WR, 16'h6000, 8'h00, 9'd0, 1'b0}));
    drain_results();

    for (int ph = 0; ph < 5; ph++) begin
      cfg_write(bsm_pkg::REG_PRG_UNITS, prg_set[ph]);
      cfg_write(bsm_pkg::REG_CHR_UNITS, chr_set[ph]);
      cfg_write(bsm_pkg::REG_FOUR_SCREEN, ph % 2);
      if (ph == 1) begin
        // Pattern bank writes with every selector and both swaps.
        for (int s = 0; s < 8; s++) begin
          pending_items.push_back(mapper_write(16'h8000, 8'(s) | 8'hC0));
          pending_items.push_back(mapper_write(16'h8001, 8'($urandom)));
          pending_items.push_back(item_t'({bsm_pkg::OP_CHR, 16'(s) << 10, 8'h0, 9'd0,
                                           1'b0}));
        end
      end
      for (int n = 0; n < 300; n++) pending_items.push_back(random_item());
      if (ph == 2) begin
        // Long receiver hold-off while the sender keeps offering items.
        hold_receiver = 1'b1;
        repeat (200) @(posedge clk);
        hold_receiver = 1'b0;
      end
      drain_results();
    end

    if (errors == 0) $display("bank_switch_mapper_scanline_irq_test: clean");
    else $display("bank_switch_mapper_scanline_irq_test: errors");
    $finish;
  end
endmodule
